### sv/ppyr_pkg.sv
`default_nettype none

package ppyr_pkg;

  // Palette geometry.
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int INDEX_W       = 8;
  localparam int CNT_W         = 9;
  localparam int CHAN_W        = 8;
  localparam int ENTRY_W       = 4 * CHAN_W;

  // Stream payload widths.
  localparam int S_DATA_W = INDEX_W + ENTRY_W;
  localparam int M_DATA_W = 4 * CHAN_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = CNT_W;

  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'b1;

  localparam logic MODE_YUVA = 1'b0;
  localparam logic MODE_RGBA = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = CNT_W'(PALETTE_DEPTH);

  // Fixed-point color conversion (10 fractional bits).
  localparam int FX_SHIFT = 10;
  localparam int YOFF_W   = 10;
  localparam int COEF_W   = 13;
  localparam int PROD_W   = 21;
  localparam int SUM_W    = 23;

  localparam logic signed [YOFF_W-1:0] Y_OFFSET   = 10'sd16;
  localparam logic signed [COEF_W-1:0] K_Y        = 13'sd1192;
  localparam logic signed [COEF_W-1:0] K_CR_R     = 13'sd1634;
  localparam logic signed [COEF_W-1:0] K_CB_G     = 13'sd401;
  localparam logic signed [COEF_W-1:0] K_CR_G     = 13'sd832;
  localparam logic signed [COEF_W-1:0] K_CB_B     = 13'sd2066;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = 23'sd512;

  // One palette entry, luma in the lowest byte.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] cr;
    logic [CHAN_W-1:0] cb;
    logic [CHAN_W-1:0] luma;
  } entry_t;

  // Control that travels with a pixel down the pipeline.
  typedef struct packed {
    logic valid;
    logic skip;
    logic rgb;
  } pix_ctrl_t;

  // Floor shift by FX_SHIFT, then saturate to 0..255.
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [CHAN_W-1:0] res;
    if (s < 0) begin
      res = '0;
    end else if (|s[SUM_W-1:FX_SHIFT+CHAN_W]) begin
      res = '1;
    end else begin
      res = s[FX_SHIFT+CHAN_W-1:FX_SHIFT];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/ppyr_ram.sv
`default_nettype none

module ppyr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/ppyr_csc.sv
`default_nettype none

module ppyr_csc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  ppyr_pkg::pix_ctrl_t           in_ctrl,
  input  ppyr_pkg::entry_t              in_entry,
  output ppyr_pkg::pix_ctrl_t           out_ctrl,
  output logic [ppyr_pkg::M_DATA_W-1:0] out_data
);

  import ppyr_pkg::*;

  pix_ctrl_t                 ctrl;
  entry_t                    entry;
  logic signed [PROD_W-1:0]  ys;
  logic signed [PROD_W-1:0]  cr_r;
  logic signed [PROD_W-1:0]  cb_g;
  logic signed [PROD_W-1:0]  cr_g;
  logic signed [PROD_W-1:0]  cb_b;

  logic signed [YOFF_W-1:0]  y_off;
  logic signed [CHAN_W-1:0]  cb_s;
  logic signed [CHAN_W-1:0]  cr_s;
  logic signed [SUM_W-1:0]   r_sum;
  logic signed [SUM_W-1:0]   g_sum;
  logic signed [SUM_W-1:0]   b_sum;
  logic [CHAN_W-1:0]         red;
  logic [CHAN_W-1:0]         green;
  logic [CHAN_W-1:0]         blue;

  // Subtracting 128 from an 8-bit code is a flip of its top bit.
  assign y_off = $signed({2'b00, in_entry.luma}) - Y_OFFSET;
  assign cb_s  = $signed({~in_entry.cb[CHAN_W-1], in_entry.cb[CHAN_W-2:0]});
  assign cr_s  = $signed({~in_entry.cr[CHAN_W-1], in_entry.cr[CHAN_W-2:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= in_entry;
      ys    <= PROD_W'(y_off) * PROD_W'(K_Y);
      cr_r  <= PROD_W'(cr_s) * PROD_W'(K_CR_R);
      cb_g  <= PROD_W'(cb_s) * PROD_W'(K_CB_G);
      cr_g  <= PROD_W'(cr_s) * PROD_W'(K_CR_G);
      cb_b  <= PROD_W'(cb_s) * PROD_W'(K_CB_B);
    end
  end

  assign r_sum = SUM_W'(ys) + SUM_W'(cr_r) + ROUND_HALF;
  assign g_sum = SUM_W'(ys) - SUM_W'(cb_g) - SUM_W'(cr_g) + ROUND_HALF;
  assign b_sum = SUM_W'(ys) + SUM_W'(cb_b) + ROUND_HALF;

  assign red   = clamp_chan(r_sum);
  assign green = clamp_chan(g_sum);
  assign blue  = clamp_chan(b_sum);

  always_comb begin
    if (ctrl.skip) begin
      out_data = '0;
    end else if (ctrl.rgb) begin
      out_data = {entry.alpha, blue, green, red};
    end else begin
      out_data = entry;
    end
  end

  assign out_ctrl = ctrl;

endmodule

`default_nettype wire

### sv/palette_pixel_to_yuva_or_rgba.sv
// Palette pixel converter: turns palettized pixels into YUVA or RGBA.
//
// The input stream (s_*) carries two kinds of request, chosen by s_tuser.
// A palette-write request stores its Y, U, V and alpha bytes at the given
// index and produces no output. A pixel request looks up the entry at its
// index and produces exactly one output request (m_*). In YUVA mode the
// entry is passed out unchanged; in RGBA mode Y, Cb and Cr are converted
// with a 10-bit fixed-point studio-range BT.601 matrix and clamped to
// 0..255, and alpha is passed through. A pixel whose index is at or above
// the programmed entry count comes out with m_tuser set and all channels 0.
//
// Timing: one request is taken every cycle unless the output is stalled.
// A pixel's result passes through the registered palette read and the
// registered products to the output register, with the sums and clamping
// in front of it. The whole pipeline stalls together when the output holds
// a result that is not taken, so s_tready is high only while the output
// register is empty or m_tready is high. Configuration writes (cfg_*) are
// always accepted and must only be issued while the block is idle. Reset
// sets RGBA mode off and the entry count to the full palette; palette
// contents are undefined until written, and no clearing pass is run.

`default_nettype none

module palette_pixel_to_yuva_or_rgba (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata, from bit 0: index[7:0], entry_luma[15:8], entry_cb[23:16],
  // entry_cr[31:24], entry_alpha[39:32].
  input  logic [ppyr_pkg::S_DATA_W-1:0]    s_tdata,
  // s_tuser: action (0 palette write, 1 pixel).
  input  logic                             s_tuser,
  // Output stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata, from bit 0: chan_first[7:0], chan_second[15:8],
  // chan_third[23:16], chan_alpha[31:24].
  output logic [ppyr_pkg::M_DATA_W-1:0]    m_tdata,
  // m_tuser: skipped.
  output logic                             m_tuser,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppyr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppyr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ppyr_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  // Configuration registers.
  logic             output_mode;
  logic [CNT_W-1:0] entry_count;

  // Pipeline.
  logic              advance;
  logic              s_accept;
  logic [INDEX_W-1:0] in_index;
  entry_t            in_entry;
  logic [CNT_W-1:0]  bound;
  logic              in_range;
  logic              in_store;
  logic              is_pixel;
  logic              is_write;
  pix_ctrl_t         s1_ctrl;
  pix_ctrl_t         s1_ctrl_next;
  entry_t            rd_entry;
  pix_ctrl_t         csc_ctrl;
  logic [M_DATA_W-1:0] csc_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= MODE_YUVA;
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTPUT_MODE: output_mode <= cfg_data[0];
        REG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Everything moves when the output register is empty or being drained.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign s_accept = s_tvalid && s_tready;

  assign in_index = s_tdata[INDEX_W-1:0];
  assign in_entry = s_tdata[S_DATA_W-1:INDEX_W];
  assign is_pixel = s_tuser == ACT_PIXEL;
  assign is_write = s_tuser == ACT_WRITE;

  // The usable bound is the smaller of the programmed count and the store.
  assign bound    = (entry_count < DEPTH_CNT) ? entry_count : DEPTH_CNT;
  assign in_range = CNT_W'(in_index) < bound;
  assign in_store = CNT_W'(in_index) < DEPTH_CNT;

  always_comb begin
    s1_ctrl_next.valid = s_accept && is_pixel;
    s1_ctrl_next.skip  = !in_range;
    s1_ctrl_next.rgb   = output_mode == MODE_RGBA;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (advance) begin
      s1_ctrl <= s1_ctrl_next;
    end
  end

  // The read port only fires on an accepted pixel, so its data register
  // holds its value through a stall.
  ppyr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (s_accept && is_write && in_store),
    .wr_addr (in_index[ADDR_W-1:0]),
    .wr_data (in_entry),
    .rd_en   (s_accept && is_pixel),
    .rd_addr (in_index[ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  ppyr_csc u_csc (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_ctrl  (s1_ctrl),
    .in_entry (rd_entry),
    .out_ctrl (csc_ctrl),
    .out_data (csc_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= csc_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= csc_data;
      m_tuser <= csc_ctrl.skip;
    end
  end

  // A skipped pixel carries no color.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("skipped result has nonzero channels");

  // A palette write never enters the result pipeline.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (s_accept && is_write) |=> !s1_ctrl.valid)
    else $error("palette write produced a pipeline slot");

  // An accepted pixel always occupies the first stage next cycle.
  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    (s_accept && is_pixel) |=> s1_ctrl.valid)
    else $error("accepted pixel lost before lookup");

  // While the output is stalled the first stage does not move.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(s1_ctrl))
    else $error("pipeline advanced during output stall");

endmodule

`default_nettype wire

### tb/tb_palette_pixel_to_yuva_or_rgba.sv
module tb_palette_pixel_to_yuva_or_rgba;
  timeunit 1ns;
  timeprecision 1ps;

  import ppyr_pkg::*;

  // Cycles allowed for a request to leave the pipeline. The block has two
  // register stages plus the output register; a palette write produces no
  // output, so it can still be in flight when the last result has arrived.
  localparam int LAT_GUARD = 8;

  // Cycles the receiver refuses output once, to back the pipeline up.
  localparam int HOLD_CYCLES = 120;

  // Random requests queued after each register setting.
  localparam int RAND_PER_SETTING = 80;

  // One input request: the action, the index and the entry bytes.
  typedef struct {
    logic               action;
    logic [INDEX_W-1:0] index;
    entry_t             entry;
  } pal_req_t;

  // One output result, field by field.
  typedef struct {
    logic [CHAN_W-1:0] ch_first;
    logic [CHAN_W-1:0] ch_second;
    logic [CHAN_W-1:0] ch_third;
    logic [CHAN_W-1:0] ch_alpha;
    logic              skipped;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  palette_pixel_to_yuva_or_rgba dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Requests waiting to be offered, and colors waiting to come out.
  pal_req_t req_queue[$];
  color_t   expected_colors[$];

  // Our own copy of the palette and of the two registers, updated only on
  // accepted requests and accepted register writes.
  entry_t           palette_copy[PALETTE_DEPTH];
  logic             model_mode;
  logic [CNT_W-1:0] model_count;

  // What the stimulus generator knows: which entries are written by the
  // requests already queued, and the bound of the current setting. A pixel
  // request never reads a valid entry that nothing has written.
  bit gen_written[PALETTE_DEPTH];
  int gen_bound = PALETTE_DEPTH;

  int errors           = 0;
  int writes_sent      = 0;
  int pixels_sent      = 0;
  int skipped_seen     = 0;
  int settings_applied = 0;
  int results_seen     = 0;
  int cycle_no         = 0;
  int hold_left        = 0;
  bit pressure_done    = 1'b0;
  pal_req_t cur_req;

  // A window in which neither side idles at random, so the pipeline can run back to back.
  wire calm = (cycle_no >= 300) && (cycle_no < 700);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Clamp a 10-bit fixed-point sum to one 8-bit channel, flooring the shift.
  function automatic logic [CHAN_W-1:0] saturate_chan(input int sum);
    int v;
    if (sum < 0) begin
      return '0;
    end
    v = sum >>> FX_SHIFT;
    if (v > 255) begin
      return '1;
    end
    return CHAN_W'(v);
  endfunction

  // Apply one accepted request to the palette copy; a pixel request also
  // queues the color it must produce.
  function automatic void convert_request(input pal_req_t r);
    color_t c;
    entry_t e;
    int     bound;
    int     y;
    int     cb;
    int     cr;
    int     ys;
    bound = (model_count < PALETTE_DEPTH) ? int'(model_count) : PALETTE_DEPTH;
    if (r.action == ACT_WRITE) begin
      palette_copy[r.index] = r.entry;
      return;
    end
    c = '{default: '0};
    if (int'(r.index) >= bound) begin
      // Out-of-range index: flagged, all channels zero, alpha too.
      c.skipped = 1'b1;
    end else begin
      e = palette_copy[r.index];
      c.ch_alpha = e.alpha;
      if (model_mode == MODE_YUVA) begin
        c.ch_first  = e.luma;
        c.ch_second = e.cb;
        c.ch_third  = e.cr;
      end else begin
        // Studio-range BT.601 to RGB with 10 fractional bits and rounding.
        y  = int'(e.luma);
        cb = int'(e.cb) - 128;
        cr = int'(e.cr) - 128;
        ys = (y - 16) * 1192;
        c.ch_first  = saturate_chan(ys + 1634 * cr + 512);
        c.ch_second = saturate_chan(ys - 401 * cb - 832 * cr + 512);
        c.ch_third  = saturate_chan(ys + 2066 * cb + 512);
      end
    end
    expected_colors.push_back(c);
  endfunction

  // Driver: offers queued requests, idles at random outside the calm window,
  // and predicts each request on the edge it is accepted. s_tvalid is
  // assigned once per edge, so a request that follows another keeps it high.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        convert_request(cur_req);
        if (cur_req.action == ACT_WRITE) begin
          writes_sent++;
        end else begin
          pixels_sent++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (req_queue.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          cur_req = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.entry, cur_req.index};
          s_tuser  <= cur_req.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random, and once refuses output for a long stretch
  // while the driver keeps offering, so the whole pipeline fills and backs up
  // onto s_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && results_seen >= 150) begin
      m_tready      <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // Register mirror: follows every accepted configuration write.
  always @(posedge clk) begin
    if (rst) begin
      model_mode  <= MODE_YUVA;
      model_count <= ENTRY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTPUT_MODE: begin
          model_mode <= cfg_data[0];
        end
        REG_ENTRY_COUNT: begin
          model_count <= cfg_data;
        end
      endcase
    end
  end

  function automatic void compare_chan(input string name, input logic [CHAN_W-1:0] want,
                                       input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Monitor: every accepted output request is checked against the oldest
  // outstanding color.
  always @(posedge clk) begin
    color_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (m_tuser) begin
        skipped_seen++;
      end
      if (expected_colors.size() == 0) begin
        $display("%0t: result with no pixel outstanding, expected none, actual %h/%b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        compare_chan("chan_first", want.ch_first, m_tdata[7:0]);
        compare_chan("chan_second", want.ch_second, m_tdata[15:8]);
        compare_chan("chan_third", want.ch_third, m_tdata[23:16]);
        compare_chan("chan_alpha", want.ch_alpha, m_tdata[31:24]);
        if (m_tuser !== want.skipped) begin
          $display("%0t: skipped mismatch, expected %0b, actual %0b",
                   $time, want.skipped, m_tuser);
          errors++;
        end
      end
    end
  end

  function automatic logic [CHAN_W-1:0] rand_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return '1;
    end
    return CHAN_W'($urandom_range(255));
  endfunction

  function automatic void queue_req(input logic action, input int idx, input int y,
                                    input int u, input int v, input int a);
    pal_req_t r;
    r.action = action;
    r.index  = INDEX_W'(idx);
    r.entry  = '{alpha: CHAN_W'(a), cr: CHAN_W'(v), cb: CHAN_W'(u), luma: CHAN_W'(y)};
    if (action == ACT_WRITE) begin
      gen_written[idx] = 1'b1;
    end
    req_queue.push_back(r);
  endfunction

  // Random traffic for the current setting. Most indices fall below a nonzero
  // bound; a pixel that would read a valid but unwritten entry becomes a
  // write to that entry instead, so the palette fills as the run goes on.
  function automatic void queue_random(input int n);
    int    idx;
    logic  action;
    repeat (n) begin
      if (gen_bound > 0 && $urandom_range(99) < 70) begin
        idx = $urandom_range(gen_bound - 1);
      end else begin
        idx = $urandom_range(255);
      end
      action = ($urandom_range(99) < 65) ? ACT_PIXEL : ACT_WRITE;
      if (action == ACT_PIXEL && idx < gen_bound && !gen_written[idx]) begin
        action = ACT_WRITE;
      end
      queue_req(action, idx, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    end
  endfunction

  // Wait until every queued request is taken and every color has come out,
  // then let any trailing palette write leave the pipeline.
  task automatic wait_idle(input int limit);
    int waited;
    waited = 0;
    while ((req_queue.size() != 0 || s_tvalid || expected_colors.size() != 0)
           && waited < limit) begin
      @(negedge clk);
      waited++;
    end
    repeat (LAT_GUARD) @(negedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic apply_setting(input logic mode, input int count);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_OUTPUT_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gen_bound = (count < PALETTE_DEPTH) ? count : PALETTE_DEPTH;
    settings_applied++;
    @(negedge clk);
  endtask

  initial begin
    logic set_mode[8];
    int   set_count[8];
    set_mode  = '{MODE_RGBA, MODE_YUVA, MODE_RGBA, MODE_YUVA,
                  MODE_RGBA, MODE_RGBA, MODE_YUVA, MODE_RGBA};
    set_count = '{256, 0, 100, 255, 1, 511, 37, 256};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: YUVA passthrough with the full palette. Entries at both
    // ends of the index range, all-zero and all-one bytes, the BT.601 black,
    // white, red and blue, and entries that saturate in RGBA mode.
    queue_req(ACT_WRITE, 0, 0, 0, 0, 0);
    queue_req(ACT_WRITE, 255, 255, 255, 255, 255);
    queue_req(ACT_WRITE, 1, 16, 128, 128, 128);
    queue_req(ACT_WRITE, 2, 235, 128, 128, 1);
    queue_req(ACT_WRITE, 3, 81, 90, 240, 255);
    queue_req(ACT_WRITE, 4, 41, 240, 110, 170);
    queue_req(ACT_WRITE, 128, 255, 0, 255, 15);
    queue_req(ACT_WRITE, 127, 0, 255, 0, 240);
    foreach (set_count[k]) begin
      if (k < 8) begin
        queue_req(ACT_PIXEL, (k < 5) ? k : ((k == 5) ? 255 : ((k == 6) ? 128 : 127)),
                  $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255));
      end
    end
    // A rewrite followed at once by reads of the same entry.
    queue_req(ACT_WRITE, 0, 170, 85, 204, 51);
    queue_req(ACT_PIXEL, 0, 0, 0, 0, 0);
    queue_req(ACT_PIXEL, 0, 255, 255, 255, 255);
    wait_idle(5000);

    for (int s = 0; s < 8; s++) begin
      apply_setting(set_mode[s], set_count[s]);
      if (s == 0) begin
        // The same fixed entries through the color conversion, including
        // results that clamp low and high.
        foreach (set_count[k]) begin
          queue_req(ACT_PIXEL, (k < 5) ? k : ((k == 5) ? 255 : ((k == 6) ? 128 : 127)),
                    0, 0, 0, 0);
        end
      end else if (s == 1) begin
        // Entry count zero: every pixel is skipped, writes still land.
        queue_req(ACT_PIXEL, 0, 0, 0, 0, 0);
        queue_req(ACT_PIXEL, 255, 0, 0, 0, 0);
      end
      queue_random(RAND_PER_SETTING);
      wait_idle(5000);
    end

    wait_idle(20000);
    if (expected_colors.size() != 0 || req_queue.size() != 0) begin
      $display("%0t: run ended with %0d results and %0d requests outstanding",
               $time, expected_colors.size(), req_queue.size());
      errors++;
    end

    $display("Covered %0d palette writes and %0d pixel lookups (%0d skipped) over %0d",
             writes_sent, pixels_sent, skipped_seen, settings_applied + 1);
    $display("register settings in both modes, with entry counts 0, 1, 255, 256 and 511.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
